// ===== hw/rtl/rtp_l16_packetizer_assert.svh =====
// Assertion macros used by the checker file of the packetizer.
`ifndef RTP_L16_PACKETIZER_ASSERT_SVH
`define RTP_L16_PACKETIZER_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define RTPL16_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define RTPL16_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rtpl16_pkg.sv =====
package rtpl16_pkg;

   // Item kinds on the request channel
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_STATUS = 1'b1
   } opcode_type;

   // Configuration register indexes
   localparam logic CSR_PAYLOAD_TYPE = 1'b0;
   localparam logic CSR_SOURCE_ID    = 1'b1;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   // RTP version 2, no padding, no extension, no CSRC
   localparam logic [7:0] RTP_FIRST_BYTE = 8'h80;

   // Byte positions within one command: header 0..11, sample 12..13
   localparam logic [3:0] IDX_FIRST     = 4'd0;
   localparam logic [3:0] IDX_PT        = 4'd1;
   localparam logic [3:0] IDX_SEQ_HI    = 4'd2;
   localparam logic [3:0] IDX_SEQ_LO    = 4'd3;
   localparam logic [3:0] IDX_TS_3      = 4'd4;
   localparam logic [3:0] IDX_TS_2      = 4'd5;
   localparam logic [3:0] IDX_TS_1      = 4'd6;
   localparam logic [3:0] IDX_TS_0      = 4'd7;
   localparam logic [3:0] IDX_SSRC_3    = 4'd8;
   localparam logic [3:0] IDX_SSRC_2    = 4'd9;
   localparam logic [3:0] IDX_SSRC_1    = 4'd10;
   localparam logic [3:0] IDX_SSRC_0    = 4'd11;
   localparam logic [3:0] IDX_SAMPLE_HI = 4'd12;
   localparam logic [3:0] IDX_SAMPLE_LO = 4'd13;

   // Command queue depth
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [15:0] sample;
      logic               last_sample;
      logic               send_ok;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
      logic       aborted;
   } rsp_type;

   // One queued unit of output work
   typedef struct packed {
      logic        header;
      logic        abort;
      logic        last;
      logic [15:0] sample;
      logic [15:0] seq;
      logic [31:0] ts;
   } cmd_type;

   // Front to queue
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   // Queue to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ===== hw/rtl/rtpl16_front.sv =====
module rtpl16_front
   import rtpl16_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 160
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     queue_full,
   output push_type push_out
);

   localparam logic [7:0] MaxSamples = 8'(MAX_SAMPLES);

   logic [15:0] seq_ff,        seq_in;
   logic [31:0] ts_ff,         ts_in;
   logic [7:0]  count_ff,      count_in;
   logic        open_ff,       open_in;
   logic [7:0]  finished_ff,   finished_in;
   logic        discarding_ff, discarding_in;

   logic       accept;
   logic [7:0] count_now;
   logic [7:0] count_next;
   logic       over_limit;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign count_now  = open_ff ? count_ff : 8'd0;
   assign count_next = count_now + 8'd1;
   assign over_limit = count_now >= MaxSamples;

   // Classify the item and update the packet state
   always_comb begin
      seq_in        = seq_ff;
      ts_in         = ts_ff;
      count_in      = count_ff;
      open_in       = open_ff;
      finished_in   = finished_ff;
      discarding_in = discarding_ff;
      push_out      = '0;
      push_out.cmd.header = !open_ff;
      push_out.cmd.abort  = over_limit;
      push_out.cmd.last   = req_data.last_sample;
      push_out.cmd.sample = req_data.sample;
      push_out.cmd.seq    = seq_ff;
      push_out.cmd.ts     = ts_ff;
      if (accept) begin
         unique case (req_data.opcode)
            OP_STATUS: begin
               if (finished_ff != 8'd0) begin
                  if (req_data.send_ok) begin
                     seq_in = seq_ff + 16'd1;
                     ts_in  = ts_ff + {24'd0, finished_ff};
                  end
                  finished_in = 8'd0;
               end
            end
            OP_SAMPLE: begin
               priority if (discarding_ff) begin
                  if (req_data.last_sample) begin
                     discarding_in = 1'b0;
                  end
               end else if (over_limit) begin
                  push_out.push = 1'b1;
                  open_in       = 1'b0;
                  count_in      = 8'd0;
                  discarding_in = !req_data.last_sample;
               end else begin
                  push_out.push = 1'b1;
                  if (req_data.last_sample) begin
                     finished_in = count_next;
                     open_in     = 1'b0;
                     count_in    = 8'd0;
                  end else begin
                     open_in  = 1'b1;
                     count_in = count_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= '0;
         ts_ff         <= '0;
         count_ff      <= '0;
         open_ff       <= 1'b0;
         finished_ff   <= '0;
         discarding_ff <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         ts_ff         <= ts_in;
         count_ff      <= count_in;
         open_ff       <= open_in;
         finished_ff   <= finished_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule

// ===== hw/rtl/rtpl16_queue.sv =====
module rtpl16_queue
   import rtpl16_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   output logic     full,
   output head_type head,
   input  logic     pop
);

   localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   fill_ff,   fill_in;

   logic do_push;
   logic do_pop;

   assign full       = fill_ff == (PtrW + 1)'(QUEUE_DEPTH);
   assign head.valid = fill_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_in.push && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PtrW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

// ===== hw/rtl/rtpl16_back.sv =====
module rtpl16_back
   import rtpl16_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  head_type               head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   logic [6:0]  payload_type_ff;
   logic [31:0] source_id_ff;

   logic        busy_ff,  busy_in;
   logic [3:0]  idx_ff,   idx_in;
   logic        valid_ff, valid_in;
   rsp_type     data_ff,  data_in;

   logic       load;
   logic       emit;
   logic [3:0] idx_now;
   logic       last_byte;
   rsp_type    byte_now;

   assign load      = !valid_ff || !rsp_stall;
   assign emit      = head.valid && load;
   assign idx_now   = busy_ff ? idx_ff : (head.cmd.header ? IDX_FIRST : IDX_SAMPLE_HI);
   assign last_byte = (head.cmd.abort && idx_now == IDX_SAMPLE_HI) || idx_now == IDX_SAMPLE_LO;
   assign pop       = emit && last_byte;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_type_ff <= 7'd96;
         source_id_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PAYLOAD_TYPE: payload_type_ff <= csr_wdata[6:0];
            CSR_SOURCE_ID:    source_id_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Select the byte at the current position
   always_comb begin
      byte_now = '0;
      unique case (idx_now)
         IDX_FIRST:     byte_now.data_byte = RTP_FIRST_BYTE;
         IDX_PT:        byte_now.data_byte = {1'b0, payload_type_ff};
         IDX_SEQ_HI:    byte_now.data_byte = head.cmd.seq[15:8];
         IDX_SEQ_LO:    byte_now.data_byte = head.cmd.seq[7:0];
         IDX_TS_3:      byte_now.data_byte = head.cmd.ts[31:24];
         IDX_TS_2:      byte_now.data_byte = head.cmd.ts[23:16];
         IDX_TS_1:      byte_now.data_byte = head.cmd.ts[15:8];
         IDX_TS_0:      byte_now.data_byte = head.cmd.ts[7:0];
         IDX_SSRC_3:    byte_now.data_byte = source_id_ff[31:24];
         IDX_SSRC_2:    byte_now.data_byte = source_id_ff[23:16];
         IDX_SSRC_1:    byte_now.data_byte = source_id_ff[15:8];
         IDX_SSRC_0:    byte_now.data_byte = source_id_ff[7:0];
         IDX_SAMPLE_HI: begin
            if (head.cmd.abort) begin
               byte_now.end_of_packet = 1'b1;
               byte_now.aborted       = 1'b1;
            end else begin
               byte_now.data_byte = head.cmd.sample[15:8];
            end
         end
         IDX_SAMPLE_LO: begin
            byte_now.data_byte     = head.cmd.sample[7:0];
            byte_now.end_of_packet = head.cmd.last;
         end
         default: begin
         end
      endcase
   end

   // Advance the sequencer and load the output register
   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = emit;
      end
      if (emit) begin
         data_in = byte_now;
         if (last_byte) begin
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            idx_in  = idx_now + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== hw/rtl/rtp_l16_packetizer.sv =====
// RTP packetizer for L16 PCM audio.
// Request channel (req_valid/req_stall/req_data): one item per sample or
// send-status report. The first sample of a packet yields a 12-byte RTP
// header followed by the two sample bytes; later samples yield two bytes.
// Status items and dropped samples yield no bytes.
// Response channel (rsp_valid/rsp_stall/rsp_data): one packet byte per item,
// end_of_packet on the last byte, aborted on the single marker byte of a
// packet that ran past MAX_SAMPLES samples.
// With the queue empty, an item is first written into the command queue; its
// first byte then goes into the output register and is presented from it.
// Throughput: the byte sequencer emits one byte per cycle while the receiver
// does not stall; a 4-entry command queue lets the front keep accepting while
// the sequencer works. Receiver stall holds the output register; the queue
// fills and then req_stall rises. Reset clears sequence number, timestamp,
// packet state and the queue, and sets payload type 96 and source id 0. The
// user makes CSR writes (csr_wr_en/csr_index/csr_wdata) while the block is
// idle; the block itself does not enforce this.
module rtp_l16_packetizer
   import rtpl16_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 160
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // Classify items and keep packet state
   rtpl16_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .queue_full(queue_full),
      .push_out  (push)
   );

   // Buffer commands between front and back
   rtpl16_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_in(push),
      .full   (queue_full),
      .head   (head),
      .pop    (pop)
   );

   // Serialize commands into bytes
   rtpl16_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hw/rtl/rtpl16_checker.sv =====
`include "rtp_l16_packetizer_assert.svh"

module rtpl16_checker
   import rtpl16_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic at_start_ff;

   // Track whether the next byte opens a packet
   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         at_start_ff <= rsp_data.end_of_packet;
      end
   end

   `RTPL16_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")

   `RTPL16_ASSERT_IMPLY(a_abort_marker, rsp_valid && rsp_data.aborted,
      rsp_data.end_of_packet && rsp_data.data_byte == 8'h00, "malformed abort marker")

   `RTPL16_ASSERT_IMPLY(a_packet_start, rsp_valid && at_start_ff,
      rsp_data.data_byte == RTP_FIRST_BYTE, "packet does not open with RTP header")

   `RTPL16_ASSERT_IMPLY(a_reset_quiet, $fell(reset), !rsp_valid,
      "response valid right after reset")

endmodule

bind rtp_l16_packetizer rtpl16_checker u_checker (.*);
